// ===== rtl/vks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vehicle kinematic step package
// Shared widths, constants and the CORDIC arctangent table for the pose
// integrator and its serial arithmetic units.
// ----------------------------------------------------------------------------
package vks_pkg;

    localparam int CORDIC_ITERS   = 16;
    localparam int POSITION_WIDTH = 32;
    localparam int CORDIC_RUN     = (CORDIC_ITERS > 24) ? 24 : CORDIC_ITERS;

    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int CORD_XY_W  = 34;
    localparam int CORD_Z_W   = 36;
    localparam int CORD_CNT_W = 5;

    localparam int DIV_N_W     = 50;
    localparam int DIV_STEPS   = DIV_N_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [24:0] FULL_TURN = 25'd23592960;
    localparam logic signed [15:0] STEER_LIMIT = 16'sd20480;
    localparam logic signed [CORD_XY_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [CORD_Z_W-1:0] HALF_TURN_Q24 = 36'sd3019898880;
    localparam logic signed [CORD_Z_W-1:0] QUARTER_TURN_Q24 = 36'sd1509949440;
    localparam logic [MUL_B_W-1:0] RAD_TO_DEG_Q16 = 32'd3754937;

    localparam logic [15:0] SPEED_GAIN_RST   = 16'd19661;
    localparam logic [15:0] STEERING_GAIN_RST = 16'd32768;
    localparam logic [15:0] INV_WHEELBASE_RST = 16'd2560;
    localparam logic [15:0] TICK_PERIOD_RST  = 16'd256;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_SPEED_GAIN    = 3'd0;
    localparam cfg_index_t REG_STEERING_GAIN = 3'd1;
    localparam cfg_index_t REG_INV_WHEELBASE = 3'd2;
    localparam cfg_index_t REG_TICK_PERIOD   = 3'd3;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    function automatic logic [29:0] atan_q24(input logic [CORD_CNT_W-1:0] idx);
        logic [29:0] val;
        unique case (idx)
            5'd0:    val = 30'd754974720;
            5'd1:    val = 30'd445687602;
            5'd2:    val = 30'd235489089;
            5'd3:    val = 30'd119537938;
            5'd4:    val = 30'd60000934;
            5'd5:    val = 30'd30029717;
            5'd6:    val = 30'd15018523;
            5'd7:    val = 30'd7509720;
            5'd8:    val = 30'd3754917;
            5'd9:    val = 30'd1877466;
            5'd10:   val = 30'd938734;
            5'd11:   val = 30'd469367;
            5'd12:   val = 30'd234684;
            5'd13:   val = 30'd117342;
            5'd14:   val = 30'd58671;
            5'd15:   val = 30'd29335;
            5'd16:   val = 30'd14668;
            5'd17:   val = 30'd7334;
            5'd18:   val = 30'd3667;
            5'd19:   val = 30'd1833;
            5'd20:   val = 30'd917;
            5'd21:   val = 30'd458;
            5'd22:   val = 30'd229;
            5'd23:   val = 30'd115;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/vks_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial signed multiplier
// Shift-and-add multiplier taking one bit of the second operand per cycle;
// the top bit carries negative weight.
// ----------------------------------------------------------------------------
module vks_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [vks_pkg::MUL_A_W-1:0]   a,
    input  logic signed [vks_pkg::MUL_B_W-1:0]   b,
    output logic                                 done,
    output logic signed [vks_pkg::MUL_P_W-1:0]   p
);
    import vks_pkg::*;

    logic signed [MUL_P_W-1:0] acc_reg, acc_next;
    logic signed [MUL_P_W-1:0] a_sh_reg, a_sh_next;
    logic [MUL_B_W-1:0]        b_sh_reg, b_sh_next;
    logic [MUL_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic signed [MUL_P_W-1:0] addend;
    logic                      last;

    always_comb
    begin
        addend    = b_sh_reg[0] ? a_sh_reg : MUL_P_W'(0);
        last      = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_sh_next = MUL_P_W'(a);
            b_sh_next = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = last ? acc_reg - addend : acc_reg + addend;
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_sh_reg <= '0;
            b_sh_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_next;
            b_sh_reg <= b_sh_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== rtl/vks_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// Folds an angle in Q.24 degrees into the right half plane and rotates the
// start vector one micro-rotation per cycle, giving cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module vks_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [vks_pkg::CORD_Z_W-1:0]    ang,
    output logic                                   done,
    output logic signed [vks_pkg::CORD_XY_W-1:0]   cos_out,
    output logic signed [vks_pkg::CORD_XY_W-1:0]   sin_out
);
    import vks_pkg::*;

    logic signed [CORD_XY_W-1:0] x_reg, x_next;
    logic signed [CORD_XY_W-1:0] y_reg, y_next;
    logic signed [CORD_Z_W-1:0]  z_reg, z_next;
    logic [CORD_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic signed [CORD_Z_W-1:0]  wrapped;
    logic signed [CORD_Z_W-1:0]  atan_step;
    logic signed [CORD_XY_W-1:0] x_sh;
    logic signed [CORD_XY_W-1:0] y_sh;
    logic                        last;

    always_comb
    begin
        if (ang > HALF_TURN_Q24)
        begin
            wrapped = ang - (HALF_TURN_Q24 <<< 1);
        end
        else if (ang < -HALF_TURN_Q24)
        begin
            wrapped = ang + (HALF_TURN_Q24 <<< 1);
        end
        else
        begin
            wrapped = ang;
        end

        atan_step = $signed(CORD_Z_W'(atan_q24(cnt_reg)));
        x_sh      = x_reg >>> cnt_reg;
        y_sh      = y_reg >>> cnt_reg;
        last      = (cnt_reg == CORD_CNT_W'(CORDIC_RUN - 1));

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            x_next    = CORDIC_START;
            y_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            if (wrapped > QUARTER_TURN_Q24)
            begin
                z_next   = wrapped - HALF_TURN_Q24;
                neg_next = 1'b1;
            end
            else if (wrapped < -QUARTER_TURN_Q24)
            begin
                z_next   = wrapped + HALF_TURN_Q24;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = wrapped;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORD_Z_W-1])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_step;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_step;
            end
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            cnt_reg  <= cnt_next;
            neg_reg  <= neg_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done    = done_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

endmodule

// ===== rtl/vehicle_kinematic_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vehicle kinematic step
// Fixed-point bicycle-model pose integrator: command transactions latch the
// targets, tick transactions lag speed and steering and advance the pose.
//
// Channel   Handshake              Payload
// item      item_valid/item_stall  kind, drive_enable, target_speed,
//                                  target_steering, time_now
// result    result_valid/...stall  speed_now, steering_now, pos_x, pos_y,
//                                  heading_now, stamp
// config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A command goes straight to the finishing step; the result register is loaded
// as the block returns to idle, before the next transaction is taken.
// A tick works through ten products on the serial multiplier, two CORDIC
// runs and two 50-step restoring divisions (tangent and heading wrap).
// One transaction is worked on at a time; the result register holds the
// last snapshot while the next transaction is taken in, and a stalled
// result holds the finished transaction back.
// Reset clears all pose state and loads the default gains.
// ----------------------------------------------------------------------------
module vehicle_kinematic_step_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic                     kind,
    input  logic                     drive_enable,
    input  logic signed [15:0]       target_speed,
    input  logic signed [15:0]       target_steering,
    input  logic [31:0]              time_now,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [15:0]       speed_now,
    output logic signed [15:0]       steering_now,
    output logic signed [31:0]       pos_x,
    output logic signed [31:0]       pos_y,
    output logic [24:0]              heading_now,
    output logic [31:0]              stamp,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  vks_pkg::cfg_index_t      cfg_index,
    input  logic [15:0]              cfg_data
);
    import vks_pkg::*;

    localparam int SUM_W = ((POSITION_WIDTH > 34) ? POSITION_WIDTH : 34) + 1;
    localparam logic signed [SUM_W-1:0] POS_HI =
        {{(SUM_W - POSITION_WIDTH + 1){1'b0}}, {(POSITION_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAG_SPEED,
        ST_LAG_STEER,
        ST_ROT_HEAD,
        ST_ROT_STEER,
        ST_X_COS,
        ST_X_STEP,
        ST_Y_SIN,
        ST_Y_STEP,
        ST_TAN_DIV,
        ST_YAW_WB,
        ST_YAW_PERIOD,
        ST_YAW_TAN,
        ST_YAW_DEG,
        ST_WRAP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;

    logic [15:0] speed_gain_reg, speed_gain_next;
    logic [15:0] steering_gain_reg, steering_gain_next;
    logic [15:0] inv_wb_reg, inv_wb_next;
    logic [15:0] period_reg, period_next;

    logic                             cmd_enable_reg, cmd_enable_next;
    logic signed [15:0]               cmd_speed_reg, cmd_speed_next;
    logic signed [15:0]               cmd_steer_reg, cmd_steer_next;
    logic signed [15:0]               speed_reg, speed_next;
    logic signed [15:0]               steer_reg, steer_next;
    logic signed [POSITION_WIDTH-1:0] x_reg, x_next;
    logic signed [POSITION_WIDTH-1:0] y_reg, y_next;
    logic [24:0]                      heading_reg, heading_next;
    logic [31:0]                      stamp_reg, stamp_next;

    logic signed [CORD_XY_W-1:0] hc_reg, hc_next;
    logic signed [CORD_XY_W-1:0] hs_reg, hs_next;
    logic signed [CORD_XY_W-1:0] sc_reg, sc_next;
    logic signed [CORD_XY_W-1:0] ss_reg, ss_next;
    logic signed [MUL_A_W-1:0]   t_reg, t_next;
    logic signed [25:0]          tanq_reg, tanq_next;

    logic [DIV_N_W-1:0]   div_n_reg, div_n_next;
    logic [CORD_XY_W-1:0] div_d_reg, div_d_next;
    logic [CORD_XY_W-1:0] div_r_reg, div_r_next;
    logic [DIV_N_W-1:0]   div_q_reg, div_q_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 div_neg_reg, div_neg_next;

    logic               result_valid_reg, result_valid_next;
    logic signed [15:0] speed_now_reg, speed_now_next;
    logic signed [15:0] steering_now_reg, steering_now_next;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic [24:0]        heading_now_reg, heading_now_next;
    logic [31:0]        stamp_out_reg, stamp_out_next;

    logic                        mul_start;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic                        mul_done;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic                        cordic_start;
    logic signed [CORD_Z_W-1:0]  cordic_ang;
    logic                        cordic_done;
    logic signed [CORD_XY_W-1:0] cordic_cos;
    logic signed [CORD_XY_W-1:0] cordic_sin;

    logic                        item_accept;
    logic signed [MUL_P_W-1:0]   lag_bias;
    logic signed [MUL_P_W-1:0]   lag_sum;
    logic signed [MUL_P_W-1:0]   lag_q;
    logic signed [16:0]          speed_diff;
    logic signed [16:0]          steer_diff;
    logic [16:0]                 speed_keep;
    logic [16:0]                 steer_keep;
    logic signed [SUM_W-1:0]     pos_d;
    logic signed [SUM_W-1:0]     pos_base;
    logic signed [SUM_W-1:0]     pos_sum;
    logic signed [SUM_W-1:0]     x_wide;
    logic signed [SUM_W-1:0]     y_wide;
    logic signed [MUL_A_W-1:0]   hsum;
    logic signed [MUL_A_W-1:0]   hsum_mag;
    logic signed [CORD_XY_W-1:0] ss_mag;
    logic [CORD_XY_W:0]          div_trial;
    logic                        div_fit;
    logic [25:0]                 tanq_mag;
    logic signed [15:0]          steer_clamped;

    function automatic logic signed [POSITION_WIDTH-1:0] pos_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] r;
        if (v > POS_HI)
        begin
            r = POS_HI;
        end
        else if (v < POS_LO)
        begin
            r = POS_LO;
        end
        else
        begin
            r = v;
        end
        return r[POSITION_WIDTH-1:0];
    endfunction

    vks_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    vks_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .ang     (cordic_ang),
        .done    (cordic_done),
        .cos_out (cordic_cos),
        .sin_out (cordic_sin)
    );

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        speed_diff = 17'(cmd_speed_reg) - 17'(speed_reg);
        steer_diff = 17'(cmd_steer_reg) - 17'(steer_reg);
        speed_keep = 17'h10000 - {1'b0, speed_gain_reg};
        steer_keep = 17'h10000 - {1'b0, steering_gain_reg};

        lag_bias = mul_p[MUL_P_W-1] ? MUL_P_W'(65535) : MUL_P_W'(0);
        lag_sum  = mul_p + lag_bias;
        lag_q    = lag_sum >>> 16;

        x_wide   = SUM_W'(x_reg);
        y_wide   = SUM_W'(y_reg);
        pos_d    = SUM_W'(mul_p >>> 8);
        pos_base = (state_reg == ST_X_STEP) ? x_wide : y_wide;
        pos_sum  = pos_base + pos_d;

        hsum     = MUL_A_W'(mul_p >>> 16) + MUL_A_W'($signed({1'b0, heading_reg}));
        hsum_mag = hsum[MUL_A_W-1] ? -hsum : hsum;
        ss_mag   = ss_reg[CORD_XY_W-1] ? -ss_reg : ss_reg;

        div_trial = {div_r_reg, div_n_reg[DIV_N_W-1]};
        div_fit   = (div_trial >= {1'b0, div_d_reg});
        tanq_mag  = {1'b0, div_q_reg[24:0]};

        if (target_steering > STEER_LIMIT)
        begin
            steer_clamped = STEER_LIMIT;
        end
        else if (target_steering < -STEER_LIMIT)
        begin
            steer_clamped = -STEER_LIMIT;
        end
        else
        begin
            steer_clamped = target_steering;
        end
    end

    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        mul_start    = 1'b0;
        cordic_start = 1'b0;
        cordic_ang   = '0;
        unique case (state_reg)
            ST_LAG_SPEED:
            begin
                mul_a = cmd_enable_reg ? MUL_A_W'(speed_diff) : MUL_A_W'(speed_reg);
                mul_b = cmd_enable_reg ? MUL_B_W'({1'b0, speed_gain_reg})
                                       : MUL_B_W'(speed_keep);
                mul_start = launch_reg;
            end
            ST_LAG_STEER:
            begin
                mul_a = cmd_enable_reg ? MUL_A_W'(steer_diff) : MUL_A_W'(steer_reg);
                mul_b = cmd_enable_reg ? MUL_B_W'({1'b0, steering_gain_reg})
                                       : MUL_B_W'(steer_keep);
                mul_start = launch_reg;
            end
            ST_ROT_HEAD:
            begin
                cordic_ang   = CORD_Z_W'($signed({1'b0, heading_reg, 8'b0}));
                cordic_start = launch_reg;
            end
            ST_ROT_STEER:
            begin
                cordic_ang   = CORD_Z_W'($signed({steer_reg, 16'b0}));
                cordic_start = launch_reg;
            end
            ST_X_COS:
            begin
                mul_a     = MUL_A_W'(hc_reg);
                mul_b     = MUL_B_W'(speed_reg);
                mul_start = launch_reg;
            end
            ST_Y_SIN:
            begin
                mul_a     = MUL_A_W'(hs_reg);
                mul_b     = MUL_B_W'(speed_reg);
                mul_start = launch_reg;
            end
            ST_X_STEP, ST_Y_STEP, ST_YAW_PERIOD:
            begin
                mul_a     = t_reg;
                mul_b     = MUL_B_W'({1'b0, period_reg});
                mul_start = launch_reg;
            end
            ST_YAW_WB:
            begin
                mul_a     = MUL_A_W'(speed_reg);
                mul_b     = MUL_B_W'({1'b0, inv_wb_reg});
                mul_start = launch_reg;
            end
            ST_YAW_TAN:
            begin
                mul_a     = t_reg;
                mul_b     = MUL_B_W'(tanq_reg);
                mul_start = launch_reg;
            end
            ST_YAW_DEG:
            begin
                mul_a     = t_reg;
                mul_b     = RAD_TO_DEG_Q16;
                mul_start = launch_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        launch_next        = 1'b0;
        speed_gain_next    = speed_gain_reg;
        steering_gain_next = steering_gain_reg;
        inv_wb_next        = inv_wb_reg;
        period_next        = period_reg;
        cmd_enable_next    = cmd_enable_reg;
        cmd_speed_next     = cmd_speed_reg;
        cmd_steer_next     = cmd_steer_reg;
        speed_next         = speed_reg;
        steer_next         = steer_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        heading_next       = heading_reg;
        stamp_next         = stamp_reg;
        hc_next            = hc_reg;
        hs_next            = hs_reg;
        sc_next            = sc_reg;
        ss_next            = ss_reg;
        t_next             = t_reg;
        tanq_next          = tanq_reg;
        div_n_next         = div_n_reg;
        div_d_next         = div_d_reg;
        div_r_next         = div_r_reg;
        div_q_next         = div_q_reg;
        div_cnt_next       = div_cnt_reg;
        div_neg_next       = div_neg_reg;
        result_valid_next  = result_valid_reg;
        speed_now_next     = speed_now_reg;
        steering_now_next  = steering_now_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        heading_now_next   = heading_now_reg;
        stamp_out_next     = stamp_out_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED_GAIN:    speed_gain_next    = cfg_data;
                REG_STEERING_GAIN: steering_gain_next = cfg_data;
                REG_INV_WHEELBASE: inv_wb_next        = cfg_data;
                REG_TICK_PERIOD:   period_next        = cfg_data;
                default:           period_next        = period_reg;
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (div_cnt_reg != DIV_CNT_W'(DIV_STEPS))
        begin
            div_r_next   = div_fit ? CORD_XY_W'(div_trial - {1'b0, div_d_reg})
                                   : div_trial[CORD_XY_W-1:0];
            div_n_next   = div_n_reg << 1;
            div_q_next   = {div_q_reg[DIV_N_W-2:0], div_fit};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (kind == KIND_TICK)
                    begin
                        stamp_next  = time_now;
                        state_next  = ST_LAG_SPEED;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        cmd_enable_next = drive_enable;
                        cmd_speed_next  = target_speed;
                        cmd_steer_next  = steer_clamped;
                        state_next      = ST_FINISH;
                    end
                end
            end
            ST_LAG_SPEED:
            begin
                if (mul_done)
                begin
                    speed_next  = cmd_enable_reg ? speed_reg + lag_q[15:0] : lag_q[15:0];
                    state_next  = ST_LAG_STEER;
                    launch_next = 1'b1;
                end
            end
            ST_LAG_STEER:
            begin
                if (mul_done)
                begin
                    steer_next  = cmd_enable_reg ? steer_reg + lag_q[15:0] : lag_q[15:0];
                    state_next  = ST_ROT_HEAD;
                    launch_next = 1'b1;
                end
            end
            ST_ROT_HEAD:
            begin
                if (cordic_done)
                begin
                    hc_next     = cordic_cos;
                    hs_next     = cordic_sin;
                    state_next  = ST_ROT_STEER;
                    launch_next = 1'b1;
                end
            end
            ST_ROT_STEER:
            begin
                if (cordic_done)
                begin
                    sc_next     = cordic_cos;
                    ss_next     = cordic_sin;
                    state_next  = ST_X_COS;
                    launch_next = 1'b1;
                end
            end
            ST_X_COS:
            begin
                if (mul_done)
                begin
                    t_next      = MUL_A_W'(mul_p >>> 22);
                    state_next  = ST_X_STEP;
                    launch_next = 1'b1;
                end
            end
            ST_X_STEP:
            begin
                if (mul_done)
                begin
                    x_next      = pos_sat(pos_sum);
                    state_next  = ST_Y_SIN;
                    launch_next = 1'b1;
                end
            end
            ST_Y_SIN:
            begin
                if (mul_done)
                begin
                    t_next      = MUL_A_W'(mul_p >>> 22);
                    state_next  = ST_Y_STEP;
                    launch_next = 1'b1;
                end
            end
            ST_Y_STEP:
            begin
                if (mul_done)
                begin
                    y_next      = pos_sat(pos_sum);
                    state_next  = ST_TAN_DIV;
                    launch_next = 1'b1;
                end
            end
            ST_TAN_DIV:
            begin
                if (launch_reg)
                begin
                    div_neg_next = ss_reg[CORD_XY_W-1];
                    div_n_next   = {ss_mag, 16'b0};
                    div_d_next   = (sc_reg < CORD_XY_W'(1)) ? CORD_XY_W'(1) : sc_reg;
                    div_r_next   = '0;
                    div_q_next   = '0;
                    div_cnt_next = '0;
                end
                else if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    tanq_next   = div_neg_reg ? -tanq_mag : tanq_mag;
                    state_next  = ST_YAW_WB;
                    launch_next = 1'b1;
                end
            end
            ST_YAW_WB:
            begin
                if (mul_done)
                begin
                    t_next      = MUL_A_W'(mul_p);
                    state_next  = ST_YAW_PERIOD;
                    launch_next = 1'b1;
                end
            end
            ST_YAW_PERIOD:
            begin
                if (mul_done)
                begin
                    t_next      = MUL_A_W'(mul_p >>> 16);
                    state_next  = ST_YAW_TAN;
                    launch_next = 1'b1;
                end
            end
            ST_YAW_TAN:
            begin
                if (mul_done)
                begin
                    t_next      = MUL_A_W'(mul_p >>> 12);
                    state_next  = ST_YAW_DEG;
                    launch_next = 1'b1;
                end
            end
            ST_YAW_DEG:
            begin
                if (mul_done)
                begin
                    div_neg_next = hsum[MUL_A_W-1];
                    div_n_next   = DIV_N_W'(hsum_mag);
                    div_d_next   = CORD_XY_W'(FULL_TURN);
                    div_r_next   = '0;
                    div_q_next   = '0;
                    div_cnt_next = '0;
                    state_next   = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    heading_next = (div_neg_reg && (div_r_reg != '0))
                                 ? 25'(CORD_XY_W'(FULL_TURN) - div_r_reg)
                                 : div_r_reg[24:0];
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    speed_now_next    = speed_reg;
                    steering_now_next = steer_reg;
                    pos_x_next        = x_wide[31:0];
                    pos_y_next        = y_wide[31:0];
                    heading_now_next  = heading_reg;
                    stamp_out_next    = stamp_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            launch_reg        <= 1'b0;
            speed_gain_reg    <= SPEED_GAIN_RST;
            steering_gain_reg <= STEERING_GAIN_RST;
            inv_wb_reg        <= INV_WHEELBASE_RST;
            period_reg        <= TICK_PERIOD_RST;
            cmd_enable_reg    <= 1'b0;
            cmd_speed_reg     <= '0;
            cmd_steer_reg     <= '0;
            speed_reg         <= '0;
            steer_reg         <= '0;
            x_reg             <= '0;
            y_reg             <= '0;
            heading_reg       <= '0;
            stamp_reg         <= '0;
            hc_reg            <= '0;
            hs_reg            <= '0;
            sc_reg            <= '0;
            ss_reg            <= '0;
            t_reg             <= '0;
            tanq_reg          <= '0;
            div_n_reg         <= '0;
            div_d_reg         <= '0;
            div_r_reg         <= '0;
            div_q_reg         <= '0;
            div_cnt_reg       <= DIV_CNT_W'(DIV_STEPS);
            div_neg_reg       <= 1'b0;
            result_valid_reg  <= 1'b0;
            speed_now_reg     <= '0;
            steering_now_reg  <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            heading_now_reg   <= '0;
            stamp_out_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            launch_reg        <= launch_next;
            speed_gain_reg    <= speed_gain_next;
            steering_gain_reg <= steering_gain_next;
            inv_wb_reg        <= inv_wb_next;
            period_reg        <= period_next;
            cmd_enable_reg    <= cmd_enable_next;
            cmd_speed_reg     <= cmd_speed_next;
            cmd_steer_reg     <= cmd_steer_next;
            speed_reg         <= speed_next;
            steer_reg         <= steer_next;
            x_reg             <= x_next;
            y_reg             <= y_next;
            heading_reg       <= heading_next;
            stamp_reg         <= stamp_next;
            hc_reg            <= hc_next;
            hs_reg            <= hs_next;
            sc_reg            <= sc_next;
            ss_reg            <= ss_next;
            t_reg             <= t_next;
            tanq_reg          <= tanq_next;
            div_n_reg         <= div_n_next;
            div_d_reg         <= div_d_next;
            div_r_reg         <= div_r_next;
            div_q_reg         <= div_q_next;
            div_cnt_reg       <= div_cnt_next;
            div_neg_reg       <= div_neg_next;
            result_valid_reg  <= result_valid_next;
            speed_now_reg     <= speed_now_next;
            steering_now_reg  <= steering_now_next;
            pos_x_reg         <= pos_x_next;
            pos_y_reg         <= pos_y_next;
            heading_now_reg   <= heading_now_next;
            stamp_out_reg     <= stamp_out_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign speed_now    = speed_now_reg;
    assign steering_now = steering_now_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign heading_now  = heading_now_reg;
    assign stamp        = stamp_out_reg;

    // The heading is always kept inside one full turn.
    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < FULL_TURN)
        else $error("heading left the range of one full turn");

    // The steering lag never carries the angle beyond the command limit.
    a_steer_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (steer_reg <= STEER_LIMIT) && (steer_reg >= -STEER_LIMIT))
        else $error("steering state outside the limit");

    // A new result is only ever presented from the final step of a transaction.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result presented outside the finishing step");

endmodule

// ===== tb/tb_vehicle_kinematic_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vehicle kinematic step testbench
// Drives command and tick transactions into the pose integrator under several
// gain settings and handshake loads. An internal fixed-point predictor works
// out each pose snapshot; each result is compared with it or a row's own pose.
// ----------------------------------------------------------------------------
module tb_vehicle_kinematic_step_top;
    import vks_pkg::*;

    typedef struct packed {
        logic signed [15:0] spd;
        logic signed [15:0] str;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [24:0]        hdg;
        logic [31:0]        stamp;
    } pose_t;

    typedef struct {
        logic               kind;
        logic               en;
        logic signed [15:0] spd;
        logic signed [15:0] str;
        logic [31:0]        t;
        bit                 known;
        pose_t              pose;
    } row_t;

    localparam longint ROT_START = 652032874;
    localparam longint TURN_Q16  = 23592960;
    localparam longint DEG_RAD   = 3754937;
    localparam longint LIMIT     = 20480;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic kind = KIND_COMMAND;
    logic drive_enable = 1'b0;
    logic signed [15:0] target_speed = '0;
    logic signed [15:0] target_steering = '0;
    logic [31:0] time_now = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [15:0] speed_now;
    logic signed [15:0] steering_now;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [24:0] heading_now;
    logic [31:0] stamp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = REG_SPEED_GAIN;
    logic [15:0] cfg_data = '0;

    vehicle_kinematic_step_top dut (.*);

    always #1 clk = ~clk;

    longint atan_tab [24] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    longint g_speed, g_steer, g_invwb, g_period;
    bit     c_en;
    longint c_spd, c_str, v_spd, v_str, v_x, v_y, v_hdg, v_stamp;

    pose_t  pose_q [$];
    int     errors = 0;
    int     n_cmd = 0;
    int     n_tick = 0;
    int     n_checked = 0;
    int     send_pct = 0;
    int     stall_pct = 0;
    bit     hold_go = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_cnt = 0;

    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint half, quarter, px, py, nx;
        bit     neg;
        int     n;
        half = 180 * 64'sd16777216;
        quarter = 90 * 64'sd16777216;
        px = ROT_START;
        py = 0;
        neg = 1'b0;
        n = (CORDIC_ITERS > 24) ? 24 : CORDIC_ITERS;
        if (ang > half) ang -= 2 * half;
        if (ang < -half) ang += 2 * half;
        if (ang > quarter) begin ang -= half; neg = 1'b1; end
        else if (ang < -quarter) begin ang += half; neg = 1'b1; end
        for (int i = 0; i < n; i++)
        begin
            if (ang >= 0)
            begin
                nx = px - (py >>> i);
                py = py + (px >>> i);
                ang -= atan_tab[i];
            end
            else
            begin
                nx = px + (py >>> i);
                py = py - (px >>> i);
                ang += atan_tab[i];
            end
            px = nx;
        end
        c = neg ? -px : px;
        s = neg ? -py : py;
    endfunction

    function automatic longint lag_to(input longint v, input longint tgt, input longint gain,
                                      input bit on);
        if (on)
            return v + (gain * (tgt - v)) / 65536;
        return ((65536 - gain) * v) / 65536;
    endfunction

    function automatic longint clip_pos(input longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (POSITION_WIDTH - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic pose_t advance_pose(input logic k, input logic en,
                                           input logic signed [15:0] spd,
                                           input logic signed [15:0] str,
                                           input logic [31:0] t);
        longint hc, hs, sc, ss, d, r, tq;
        pose_t p;
        if (k == KIND_COMMAND)
        begin
            c_en = en;
            c_spd = spd;
            c_str = str;
            if (c_str > LIMIT) c_str = LIMIT;
            if (c_str < -LIMIT) c_str = -LIMIT;
        end
        else
        begin
            v_spd = lag_to(v_spd, c_spd, g_speed, c_en);
            v_str = lag_to(v_str, c_str, g_steer, c_en);
            rotate(v_hdg * 256, hc, hs);
            rotate(v_str * 65536, sc, ss);
            d = (((v_spd * hc) >>> 22) * g_period) >>> 8;
            v_x = clip_pos(v_x + d);
            d = (((v_spd * hs) >>> 22) * g_period) >>> 8;
            v_y = clip_pos(v_y + d);
            if (sc < 1) sc = 1;
            tq = (ss * 65536) / sc;
            r = (v_spd * g_invwb * g_period) >>> 16;
            r = (r * tq) >>> 12;
            r = (r * DEG_RAD) >>> 16;
            v_hdg = ((v_hdg + r) % TURN_Q16 + TURN_Q16) % TURN_Q16;
            v_stamp = t;
        end
        p.spd = v_spd[15:0];
        p.str = v_str[15:0];
        p.x = v_x[31:0];
        p.y = v_y[31:0];
        p.hdg = v_hdg[24:0];
        p.stamp = v_stamp[31:0];
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pose_t w;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pose_q.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                w = pose_q.pop_front();
                n_checked++;
                if (speed_now !== w.spd) report_mismatch("speed_now", speed_now, w.spd);
                if (steering_now !== w.str) report_mismatch("steering_now", steering_now, w.str);
                if (pos_x !== w.x) report_mismatch("pos_x", pos_x, w.x);
                if (pos_y !== w.y) report_mismatch("pos_y", pos_y, w.y);
                if (heading_now !== w.hdg) report_mismatch("heading_now", heading_now, w.hdg);
                if (stamp !== w.stamp) report_mismatch("stamp", stamp, w.stamp);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            result_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= 3000) hold_done <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input row_t rw);
        pose_t p;
        while ($urandom_range(99) < send_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        kind = rw.kind;
        drive_enable = rw.en;
        target_speed = rw.spd;
        target_steering = rw.str;
        time_now = rw.t;
        do @(posedge clk); while (item_stall);
        p = advance_pose(rw.kind, rw.en, rw.spd, rw.str, rw.t);
        pose_q.push_back(rw.known ? rw.pose : p);
        if (rw.kind == KIND_TICK) n_tick++; else n_cmd++;
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SPEED_GAIN:    g_speed = val;
            REG_STEERING_GAIN: g_steer = val;
            REG_INV_WHEELBASE: g_invwb = val;
            REG_TICK_PERIOD:   g_period = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_and_set(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c, input logic [15:0] d);
        item_valid = 1'b0;
        while (pose_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        write_reg(REG_SPEED_GAIN, a);
        write_reg(REG_STEERING_GAIN, b);
        write_reg(REG_INV_WHEELBASE, c);
        write_reg(REG_TICK_PERIOD, d);
    endtask

    task automatic random_items(input int count);
        row_t rw;
        for (int i = 0; i < count; i++)
        begin
            rw.kind = ($urandom_range(99) < 55) ? KIND_TICK : KIND_COMMAND;
            rw.en = ($urandom_range(99) < 80);
            rw.spd = 16'($urandom);
            if ($urandom_range(3) == 0)
                rw.str = 16'($urandom);
            else
                rw.str = 16'(int'($urandom_range(40960)) - 20480);
            rw.t = $urandom;
            rw.known = 1'b0;
            send_item(rw);
        end
    endtask

    row_t dir [] = '{
        '{KIND_COMMAND, 1'b0, 16'sd0, 16'sd0, 32'd5, 1'b1, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'hFFFFFFFF, 1'b1,
          '{16'sd0, 16'sd0, 32'sd0, 32'sd0, 25'd0, 32'hFFFFFFFF}},
        '{KIND_COMMAND, 1'b1, 16'sh7FFF, 16'sh7FFF, 32'd0, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'd1, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b1, 16'sh7FFF, 16'sh7FFF, 32'd2, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'hAAAA5555, 1'b0, pose_t'(0)},
        '{KIND_COMMAND, 1'b1, -16'sh8000, -16'sh8000, 32'd0, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b1, 16'sd0, 16'sd0, 32'h5555AAAA, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'd7, 1'b0, pose_t'(0)},
        '{KIND_COMMAND, 1'b1, 16'sd256, 16'sd20480, 32'd0, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b1, 16'sd0, 16'sd0, 32'd8, 1'b0, pose_t'(0)},
        '{KIND_COMMAND, 1'b1, -16'sd512, 16'sd20481, 32'd0, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'd9, 1'b0, pose_t'(0)},
        '{KIND_COMMAND, 1'b1, 16'sd1000, -16'sd20481, 32'd0, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'd10, 1'b0, pose_t'(0)},
        '{KIND_COMMAND, 1'b0, 16'sd1000, -16'sd20480, 32'd0, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'd11, 1'b0, pose_t'(0)},
        '{KIND_TICK, 1'b0, 16'sd0, 16'sd0, 32'd12, 1'b0, pose_t'(0)}
    };

    initial
    begin
        g_speed = SPEED_GAIN_RST;
        g_steer = STEERING_GAIN_RST;
        g_invwb = INV_WHEELBASE_RST;
        g_period = TICK_PERIOD_RST;
        c_en = 1'b0;
        {c_spd, c_str, v_spd, v_str, v_x, v_y, v_hdg, v_stamp} = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir[i]) send_item(dir[i]);
        random_items(150);

        drain_and_set(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        send_pct = 77;
        random_items(200);

        drain_and_set(16'd0, 16'd0, 16'd1, 16'd1);
        write_reg(cfg_index_t'(5), 16'hFFFF);
        write_reg(cfg_index_t'(7), 16'h0000);
        send_pct = 0;
        stall_pct = 77;
        random_items(150);

        drain_and_set(16'd40000, 16'd12000, 16'd5000, 16'd4000);
        send_pct = 29;
        stall_pct = 29;
        hold_go = 1'b1;
        random_items(250);

        drain_and_set(16'($urandom), 16'($urandom),
                      16'($urandom_range(65535, 1)), 16'($urandom_range(2048, 1)));
        send_pct = 0;
        stall_pct = 0;
        random_items(200);

        drain_and_set(SPEED_GAIN_RST, STEERING_GAIN_RST, INV_WHEELBASE_RST, TICK_PERIOD_RST);
        send_pct = 77;
        stall_pct = 77;
        random_items(230);

        item_valid = 1'b0;
        while (pose_q.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        $display("Covered %0d command and %0d tick transactions, %0d results checked,",
                 n_cmd, n_tick, n_checked);
        $display("across six phases of gain settings and handshake loads.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vks_pkg.sv
rtl/vks_mul.sv
rtl/vks_cordic.sv
rtl/vehicle_kinematic_step_top.sv
tb/tb_vehicle_kinematic_step_top.sv
